// ===== rtl/psg_pkg.sv =====
// Package for the periodic staggered gradient unit: widths, register
// indexes, component codes and size clamping. No dependencies.
package psg_pkg;
   localparam int DEF_MAX_X = 64;
   localparam int DEF_MAX_Y = 64;
   localparam int DEF_MAX_Z = 64;
   localparam int DEF_SAMPLE_BITS = 32;
   localparam int SIZE_W = 7;
   localparam int STEP_W = 24;
   localparam int GRAD_W = 32;
   localparam int COMP_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_Z = 3'd5;

   localparam logic [COMP_W-1:0] COMP_X = 2'd0;
   localparam logic [COMP_W-1:0] COMP_Y = 2'd1;
   localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

   // one pending result of the job list
   typedef struct packed {
      logic [COMP_W-1:0] comp;
      logic [SIZE_W-1:0] fx;
      logic [SIZE_W-1:0] fy;
      logic [SIZE_W-1:0] fz;
      logic              last;
      logic              done;
   } tag_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw,
                                                    input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] r;
      begin
         r = raw;
         if (raw == '0) r = SIZE_W'(1);
         else if (raw > lim) r = lim;
         return r;
      end
   endfunction
endpackage

// ===== rtl/psg_scale.sv =====
// Scaling pipeline: difference, magnitude times reciprocal spacing,
// rounding and saturation. Uses psg_pkg. Three stages with stall.
module psg_scale
   import psg_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_a,
   input  logic [SAMPLE_BITS-1:0] in_b,
   input  logic [STEP_W-1:0]      in_step,
   input  tag_type                in_tag,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [GRAD_W-1:0]      out_grad,
   output tag_type                out_tag
);
   localparam int DW = SAMPLE_BITS + 1;
   localparam int PW = DW + STEP_W;

   logic v1_ff, v2_ff, v3_ff;
   logic [DW-1:0] mag1_ff;
   logic neg1_ff, neg2_ff;
   logic [STEP_W-1:0] step1_ff;
   tag_type tag1_ff, tag2_ff, tag3_ff;
   logic [PW-1:0] prod2_ff;
   logic [GRAD_W-1:0] grad3_ff;
   logic adv1, adv2, adv3;
   logic [DW-1:0] diff_in;
   logic [PW-1:0] q_in;
   logic [PW-1:0] pos_lim;
   logic [GRAD_W-1:0] grad_in;
   logic [SAMPLE_BITS-1:0] sat_in;

   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;

   assign diff_in = {in_a[SAMPLE_BITS-1], in_a} - {in_b[SAMPLE_BITS-1], in_b};

   always_comb begin
      pos_lim = PW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      q_in = (prod2_ff + PW'(32'h8000)) >> 16;
      if (neg2_ff) begin
         if (q_in > pos_lim + PW'(1)) q_in = pos_lim + PW'(1);
         sat_in = SAMPLE_BITS'(PW'(0) - q_in);
      end else begin
         if (q_in > pos_lim) q_in = pos_lim;
         sat_in = SAMPLE_BITS'(q_in);
      end
      grad_in = GRAD_W'(signed'(sat_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) begin
         neg1_ff  <= diff_in[DW-1];
         mag1_ff  <= diff_in[DW-1] ? DW'(0) - diff_in : diff_in;
         step1_ff <= in_step;
         tag1_ff  <= in_tag;
      end
      if (adv2) begin
         neg2_ff  <= neg1_ff;
         prod2_ff <= PW'(mag1_ff) * PW'(step1_ff);
         tag2_ff  <= tag1_ff;
      end
      if (adv3) begin
         grad3_ff <= grad_in;
         tag3_ff  <= tag2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_grad  = grad3_ff;
   assign out_tag   = tag3_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !out_ready |=> v3_ff && $stable(grad3_ff))
      else $error("result dropped under stall");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      adv2 && v1_ff && step1_ff == '0 |=> prod2_ff == '0)
      else $error("zero spacing gave nonzero product");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v1_ff)
      else $error("accepted job lost");
`endif
endmodule

// ===== rtl/periodic_staggered_gradient_unit.sv =====
// Periodic staggered gradient unit, top level. Uses psg_pkg and
// psg_scale. Holds position counters and the four line/plane memories.
//
// Takes one potential word per cycle while req_ready is high, in raster
// order, and emits 0 to 9 gradient words per sample. The expansion
// sequencer issues one result job per cycle unless the scaling pipeline
// stalls, and takes the next sample as its last job is issued. Memory
// reads are issued when a sample is accepted and consumed by its jobs;
// a one-entry forward covers back-to-back samples of the same row entry.
module periodic_staggered_gradient_unit
   import psg_pkg::*;
#(
   parameter int MAX_X = DEF_MAX_X,
   parameter int MAX_Y = DEF_MAX_Y,
   parameter int MAX_Z = DEF_MAX_Z,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_potential,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COMP_W-1:0]      rsp_component,
   output logic [SIZE_W-1:0]      rsp_face_x,
   output logic [SIZE_W-1:0]      rsp_face_y,
   output logic [SIZE_W-1:0]      rsp_face_z,
   output logic [GRAD_W-1:0]      rsp_gradient,
   output logic                   rsp_last_of_run,
   output logic                   rsp_volume_done,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);
   localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int PD = MAX_X * MAX_Y;
   localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
   localparam logic [SIZE_W-1:0] LIM_X = SIZE_W'(MAX_X);
   localparam logic [SIZE_W-1:0] LIM_Y = SIZE_W'(MAX_Y);
   localparam logic [SIZE_W-1:0] LIM_Z = SIZE_W'(MAX_Z);
   localparam int SB = SAMPLE_BITS;

   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [STEP_W-1:0] step_x_ff, step_y_ff, step_z_ff;
   logic [SIZE_W-1:0] nx, ny, nz;
   logic [XW-1:0] pos_x_ff, pos_x_in;
   logic [YW-1:0] pos_y_ff, pos_y_in;
   logic [ZW-1:0] pos_z_ff, pos_z_in;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic [ZW-1:0] cz;
   logic lx, ly, lz;
   logic [PAW-1:0] pidx;
   logic size_wr;

   logic [SB-1:0] prev_row_mem [MAX_X];
   logic [SB-1:0] first_row_mem [MAX_X];
   logic [SB-1:0] prev_plane_mem [PD];
   logic [SB-1:0] first_plane_mem [PD];
   logic [SB-1:0] prow_rd_ff, frow_rd_ff, ppl_rd_ff, fpl_rd_ff;

   // sample being expanded
   logic busy_ff;
   logic [SB-1:0] cur_ff, prev_sample_ff, row_first_ff;
   logic [SB-1:0] prev_sample_in, row_first_in;
   logic [XW-1:0] sx_ff;
   logic [YW-1:0] sy_ff;
   logic [ZW-1:0] sz_ff;
   logic slx_ff, sly_ff, slz_ff;
   logic [8:0] todo_ff, todo_in;
   logic [SB-1:0] old_prev_ff, old_rowfirst_ff;
   // forward for row memories when the same x is written by one sample and read by the next
   logic fwd_prow_ff, fwd_frow_ff;
   logic [SB-1:0] fwd_data_ff;

   logic [8:0] req_mask;
   logic [3:0] pick;
   logic job_valid, job_ready, job_fire, accept;
   logic [SB-1:0] job_a, job_b, prow_v, frow_v;
   logic [STEP_W-1:0] job_step;
   tag_type job_tag;
   logic [8:0] rest;
   logic [GRAD_W-1:0] s_grad;
   tag_type s_tag;

   assign nx = clamp_size(size_x_ff, LIM_X);
   assign ny = clamp_size(size_y_ff, LIM_Y);
   assign nz = clamp_size(size_z_ff, LIM_Z);
   assign cx = (SIZE_W'(pos_x_ff) < nx) ? pos_x_ff : XW'(nx - SIZE_W'(1));
   assign cy = (SIZE_W'(pos_y_ff) < ny) ? pos_y_ff : YW'(ny - SIZE_W'(1));
   assign cz = (SIZE_W'(pos_z_ff) < nz) ? pos_z_ff : ZW'(nz - SIZE_W'(1));
   assign lx = SIZE_W'(cx) == nx - SIZE_W'(1);
   assign ly = SIZE_W'(cy) == ny - SIZE_W'(1);
   assign lz = SIZE_W'(cz) == nz - SIZE_W'(1);
   assign pidx = PAW'(cy * MAX_X + cx);

   assign req_mask = {lz, lz, (cz != '0), ly, ly, (cy != '0), lx, lx, (cx != '0)};
   assign req_ready = !busy_ff || (todo_ff == '0) ||
                      (job_fire && rest == '0);
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign size_wr = csr_valid && csr_ready &&
                    (csr_index == REG_SIZE_X || csr_index == REG_SIZE_Y ||
                     csr_index == REG_SIZE_Z);

   assign prow_v = fwd_prow_ff ? fwd_data_ff : prow_rd_ff;
   assign frow_v = fwd_frow_ff ? fwd_data_ff : frow_rd_ff;

   always_comb begin
      pick = 4'd0;
      for (int i = 8; i >= 0; i--) if (todo_ff[i]) pick = 4'(i);
      rest = todo_ff & ~(9'd1 << pick);
   end

   always_comb begin
      job_a = cur_ff;
      job_b = old_prev_ff;
      job_step = step_x_ff;
      job_tag.comp = COMP_X;
      job_tag.fx = SIZE_W'(sx_ff);
      job_tag.fy = SIZE_W'(sy_ff);
      job_tag.fz = SIZE_W'(sz_ff);
      job_tag.last = (rest == '0);
      job_tag.done = (rest == '0) && slx_ff && sly_ff && slz_ff;
      unique case (pick)
         4'd0: ;
         4'd1, 4'd2: begin
            job_a = old_rowfirst_ff;
            job_b = cur_ff;
            job_tag.fx = (pick == 4'd1) ? '0 : nx;
         end
         4'd3: begin
            job_b = prow_v;
            job_step = step_y_ff;
            job_tag.comp = COMP_Y;
         end
         4'd4, 4'd5: begin
            job_a = (sy_ff == '0) ? cur_ff : frow_v;
            job_b = cur_ff;
            job_step = step_y_ff;
            job_tag.comp = COMP_Y;
            job_tag.fy = (pick == 4'd4) ? '0 : ny;
         end
         4'd6: begin
            job_b = ppl_rd_ff;
            job_step = step_z_ff;
            job_tag.comp = COMP_Z;
         end
         default: begin
            job_a = (sz_ff == '0) ? cur_ff : fpl_rd_ff;
            job_b = cur_ff;
            job_step = step_z_ff;
            job_tag.comp = COMP_Z;
            job_tag.fz = (pick == 4'd7) ? '0 : nz;
         end
      endcase
   end

   assign job_valid = busy_ff && todo_ff != '0;
   assign job_fire = job_valid && job_ready;

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      prev_sample_in = prev_sample_ff;
      row_first_in = row_first_ff;
      if (accept) begin
         prev_sample_in = req_potential;
         if (cx == '0) row_first_in = req_potential;
         if (!lx) begin
            pos_x_in = cx + XW'(1); pos_y_in = cy; pos_z_in = cz;
         end else begin
            pos_x_in = '0;
            if (!ly) begin
               pos_y_in = cy + YW'(1); pos_z_in = cz;
            end else begin
               pos_y_in = '0;
               pos_z_in = lz ? '0 : cz + ZW'(1);
            end
         end
      end
      if (size_wr) begin
         pos_x_in = '0; pos_y_in = '0; pos_z_in = '0;
      end
      todo_in = todo_ff;
      if (job_fire) todo_in = rest;
      if (accept) todo_in = req_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_W'(64); size_y_ff <= SIZE_W'(64); size_z_ff <= SIZE_W'(64);
         step_x_ff <= STEP_W'(65536); step_y_ff <= STEP_W'(65536);
         step_z_ff <= STEP_W'(65536);
         pos_x_ff <= '0; pos_y_ff <= '0; pos_z_ff <= '0;
         busy_ff <= 1'b0;
         todo_ff <= '0;
         fwd_prow_ff <= 1'b0;
         fwd_frow_ff <= 1'b0;
      end else begin
         pos_x_ff <= pos_x_in; pos_y_ff <= pos_y_in; pos_z_ff <= pos_z_in;
         todo_ff <= todo_in;
         if (accept) busy_ff <= 1'b1;
         else if (job_fire && rest == '0) busy_ff <= 1'b0;
         fwd_prow_ff <= accept && busy_ff && sx_ff == cx;
         fwd_frow_ff <= accept && busy_ff && sx_ff == cx && sy_ff == '0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_SIZE_X: size_x_ff <= csr_data[SIZE_W-1:0];
               REG_SIZE_Y: size_y_ff <= csr_data[SIZE_W-1:0];
               REG_SIZE_Z: size_z_ff <= csr_data[SIZE_W-1:0];
               REG_STEP_X: step_x_ff <= csr_data[STEP_W-1:0];
               REG_STEP_Y: step_y_ff <= csr_data[STEP_W-1:0];
               REG_STEP_Z: step_z_ff <= csr_data[STEP_W-1:0];
               default: ;
            endcase
         end
      end
      prev_sample_ff <= prev_sample_in;
      row_first_ff <= row_first_in;
      if (accept) begin
         cur_ff <= req_potential;
         old_prev_ff <= prev_sample_ff;
         old_rowfirst_ff <= row_first_in;
         fwd_data_ff <= cur_ff;
         sx_ff <= cx; sy_ff <= cy; sz_ff <= cz;
         slx_ff <= lx; sly_ff <= ly; slz_ff <= lz;
      end
   end

   // read old values and write the new sample in the same cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         prow_rd_ff <= prev_row_mem[cx];
         frow_rd_ff <= first_row_mem[cx];
         ppl_rd_ff  <= prev_plane_mem[pidx];
         fpl_rd_ff  <= first_plane_mem[pidx];
         prev_row_mem[cx] <= req_potential;
         prev_plane_mem[pidx] <= req_potential;
         if (cy == '0) first_row_mem[cx] <= req_potential;
         if (cz == '0) first_plane_mem[pidx] <= req_potential;
      end
   end

   psg_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (job_valid),
      .in_ready (job_ready),
      .in_a     (job_a),
      .in_b     (job_b),
      .in_step  (job_step),
      .in_tag   (job_tag),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_grad (s_grad),
      .out_tag  (s_tag)
   );

   assign rsp_gradient = s_grad;
   assign rsp_component = s_tag.comp;
   assign rsp_face_x = s_tag.fx;
   assign rsp_face_y = s_tag.fy;
   assign rsp_face_z = s_tag.fz;
   assign rsp_last_of_run = s_tag.last;
   assign rsp_volume_done = s_tag.done;

`ifndef SYNTHESIS
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> todo_ff == '0)
      else $error("jobs pending while idle");
   a_last: assert property (@(posedge clock) disable iff (reset)
      job_fire && rest == '0 |-> job_tag.last)
      else $error("final job not marked");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      accept && !lx |=> pos_x_ff == $past(cx) + XW'(1) || $past(csr_valid))
      else $error("x position did not advance");
`endif
endmodule

// ===== test/tb_periodic_staggered_gradient_unit.sv =====
// Testbench for periodic_staggered_gradient_unit: streams potential volumes under
// changing sizes and spacings and checks every gradient word against a built-in
// predictor. Depends on psg_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_periodic_staggered_gradient_unit;
   import psg_pkg::*;

   typedef struct {
      logic [COMP_W-1:0] comp;
      logic [SIZE_W-1:0] fx;
      logic [SIZE_W-1:0] fy;
      logic [SIZE_W-1:0] fz;
      logic [GRAD_W-1:0] grad;
      logic              last;
      logic              done;
   } face_word_type;

   class gradient_scoreboard;
      int unsigned size_raw[3];
      longint unsigned inv_step[3];
      int pos_x, pos_y, pos_z;
      longint prev_sample, row_first;
      longint prev_row[64];
      longint first_row[64];
      longint prev_plane[4096];
      longint first_plane[4096];
      face_word_type expected_faces[$];
      int errors;
      int checked;
      int samples;

      function new();
         for (int i = 0; i < 3; i++) begin
            size_raw[i] = 64;
            inv_step[i] = 65536;
         end
         pos_x = 0; pos_y = 0; pos_z = 0;
         errors = 0; checked = 0; samples = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: begin
               size_raw[idx] = 32'(data[SIZE_W-1:0]);
               pos_x = 0; pos_y = 0; pos_z = 0;
            end
            REG_STEP_X: inv_step[0] = 64'(data[STEP_W-1:0]);
            REG_STEP_Y: inv_step[1] = 64'(data[STEP_W-1:0]);
            REG_STEP_Z: inv_step[2] = 64'(data[STEP_W-1:0]);
            default: ;
         endcase
      endfunction

      function int cells(int axis);
         if (size_raw[axis] == 0) return 1;
         if (size_raw[axis] > 64) return 64;
         return size_raw[axis];
      endfunction

      function logic [GRAD_W-1:0] scaled(longint d, longint unsigned inv);
         longint unsigned mag, q;
         mag = (d < 0) ? longint'(-d) : longint'(d);
         q = (mag * inv + 64'h8000) >> 16;
         if (d < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return GRAD_W'(-q);
         end
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         return GRAD_W'(q);
      endfunction

      function void push(logic [COMP_W-1:0] c, int fx, int fy, int fz, logic [GRAD_W-1:0] g);
         face_word_type w;
         w.comp = c; w.fx = SIZE_W'(fx); w.fy = SIZE_W'(fy); w.fz = SIZE_W'(fz);
         w.grad = g;
         w.last = 0; w.done = 0;
         expected_faces.push_back(w);
      endfunction

      function void note_sample(logic [GRAD_W-1:0] p);
         longint cur;
         int nx, ny, nz, x, y, z, pidx, k0;
         bit lx, ly, lz;
         logic [GRAD_W-1:0] g;
         cur = longint'(signed'(p));
         nx = cells(0); ny = cells(1); nz = cells(2);
         x = (pos_x < nx) ? pos_x : nx - 1;
         y = (pos_y < ny) ? pos_y : ny - 1;
         z = (pos_z < nz) ? pos_z : nz - 1;
         lx = (x == nx - 1); ly = (y == ny - 1); lz = (z == nz - 1);
         pidx = y * 64 + x;
         k0 = expected_faces.size();
         samples++;
         if (x == 0) row_first = cur;
         if (y == 0) first_row[x] = cur;
         if (z == 0) first_plane[pidx] = cur;
         if (x > 0) push(COMP_X, x, y, z, scaled(cur - prev_sample, inv_step[0]));
         if (lx) begin
            g = scaled(row_first - cur, inv_step[0]);
            push(COMP_X, 0, y, z, g);
            push(COMP_X, nx, y, z, g);
         end
         if (y > 0) push(COMP_Y, x, y, z, scaled(cur - prev_row[x], inv_step[1]));
         if (ly) begin
            g = scaled(first_row[x] - cur, inv_step[1]);
            push(COMP_Y, x, 0, z, g);
            push(COMP_Y, x, ny, z, g);
         end
         if (z > 0) push(COMP_Z, x, y, z, scaled(cur - prev_plane[pidx], inv_step[2]));
         if (lz) begin
            g = scaled(first_plane[pidx] - cur, inv_step[2]);
            push(COMP_Z, x, y, 0, g);
            push(COMP_Z, x, y, nz, g);
         end
         prev_sample = cur;
         prev_row[x] = cur;
         prev_plane[pidx] = cur;
         if (expected_faces.size() > k0) begin
            expected_faces[$].last = 1;
            expected_faces[$].done = lx && ly && lz;
         end
         if (!lx) pos_x = x + 1;
         else begin
            pos_x = 0;
            if (!ly) pos_y = y + 1;
            else begin
               pos_y = 0;
               pos_z = lz ? 0 : z + 1;
            end
         end
      endfunction

      function void check_word(face_word_type got);
         face_word_type want;
         if (expected_faces.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: comp %0d face %0d/%0d/%0d grad %h",
                        got.comp, got.fx, got.fy, got.fz, got.grad);
            return;
         end
         want = expected_faces.pop_front();
         checked++;
         if (got != want) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: exp comp %0d face %0d/%0d/%0d grad %h last %b done %b",
                        want.comp, want.fx, want.fy, want.fz, want.grad, want.last,
                        want.done);
               $display("          got comp %0d face %0d/%0d/%0d grad %h last %b done %b",
                        got.comp, got.fx, got.fy, got.fz, got.grad, got.last,
                        got.done);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [GRAD_W-1:0] req_potential = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [COMP_W-1:0] rsp_component;
   logic [SIZE_W-1:0] rsp_face_x, rsp_face_y, rsp_face_z;
   logic [GRAD_W-1:0] rsp_gradient;
   logic rsp_last_of_run, rsp_volume_done;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   gradient_scoreboard sb = new();
   int burst_left = 0;
   int phases = 0;
   int stall_mode = 0;
   int cycle_count = 0;

   periodic_staggered_gradient_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_potential(req_potential),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_component(rsp_component),
      .rsp_face_x(rsp_face_x), .rsp_face_y(rsp_face_y), .rsp_face_z(rsp_face_z),
      .rsp_gradient(rsp_gradient), .rsp_last_of_run(rsp_last_of_run),
      .rsp_volume_done(rsp_volume_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      face_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         w.comp = rsp_component; w.fx = rsp_face_x; w.fy = rsp_face_y;
         w.fz = rsp_face_z; w.grad = rsp_gradient;
         w.last = rsp_last_of_run; w.done = rsp_volume_done;
         sb.check_word(w);
      end
      cycle_count++;
      if (cycle_count % 50 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= cycle_count[3];
      endcase
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value, int bits);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data = (data & ~((32'd1 << bits) - 1)) | (value & ((32'd1 << bits) - 1));
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.expected_faces.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic configure(int sx, int sy, int sz, int ix, int iy, int iz);
      drain();
      phases++;
      write_csr(REG_SIZE_X, sx, SIZE_W);
      write_csr(REG_SIZE_Y, sy, SIZE_W);
      write_csr(REG_SIZE_Z, sz, SIZE_W);
      write_csr(REG_STEP_X, ix, STEP_W);
      write_csr(REG_STEP_Y, iy, STEP_W);
      write_csr(REG_STEP_Z, iz, STEP_W);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_IDX_W'($urandom_range(6, 7)), $urandom, 32);
      csr_valid <= 0;
   endtask

   task automatic send_word(logic [GRAD_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1;
      req_potential <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(v);
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(65, 127);
      if (r == 2) return 64;
      return $urandom_range(1, 5);
   endfunction

   function automatic int pick_step();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 24'hFFFFFF;
         2: return 65536;
         default: return $urandom_range(0, 24'hFFFFFF);
      endcase
   endfunction

   initial begin
      int rand_items, n, vol, hold_at;
      logic [GRAD_W-1:0] extremes[8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                         32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                         32'h1, 32'h8000_0000};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      configure(2, 2, 2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      foreach (extremes[i]) send_word(extremes[i]);
      configure(1, 1, 1, 65536, 65536, 65536);
      send_word($urandom); send_word($urandom);
      configure(3, 1, 2, 0, 65536, 1);
      for (int i = 0; i < 6; i++) send_word($urandom);
      configure(0, 2, 1, 65536, 0, 24'hFFFFFF);
      for (int i = 0; i < 4; i++) send_word($urandom);

      rand_items = 0;
      while (rand_items < 380) begin
         int sx, sy, sz;
         sx = pick_size(); sy = pick_size(); sz = pick_size();
         if (sx == 0 || sx > 5) begin
            if (sy > 5) sy = 2;
            if (sz > 5) sz = 1;
         end
         if (sy == 0 || sy > 5) if (sz > 5) sz = 1;
         configure(sx, sy, sz, pick_step(), pick_step(), pick_step());
         vol = sb.cells(0) * sb.cells(1) * sb.cells(2);
         n = (vol <= 40) ? vol * $urandom_range(1, 2) + $urandom_range(0, 2)
                         : $urandom_range(10, 40);
         hold_at = (phases == 5 || $urandom_range(0, 4) == 0) ? $urandom_range(1, n) : -1;
         for (int i = 0; i < n; i++) begin
            if (i == hold_at) begin
               req_valid <= 0;
               @(posedge clock);
               while (sb.expected_faces.size() != 0) @(posedge clock);
            end
            send_word($urandom);
         end
         rand_items += n;
      end

      drain();
      $display("covered %0d samples and %0d gradient words over %0d register settings",
               sb.samples, sb.checked, phases);
      if (sb.errors == 0 && sb.expected_faces.size() == 0) begin
         $display("tb_periodic_staggered_gradient_unit: clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("tb_periodic_staggered_gradient_unit: errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d words outstanding", sb.expected_faces.size());
      $display("tb_periodic_staggered_gradient_unit: errors");
      $finish;
   end
endmodule
